// ===== hw/rtl/swrd_pkg.sv =====
// ============================================================================
// swrd_pkg
// Shared types and constants for the sliding-window range detector.
// ============================================================================
package swrd_pkg;

    // Sizing
    localparam int WINDOW_MAX   = 1024;
    localparam int POSITION_MAX = 1048576;
    localparam int SAMPLE_BITS  = 20;

    localparam int WIN_IDX_W = $clog2(WINDOW_MAX);
    localparam int POS_W     = $clog2(POSITION_MAX + 1);
    localparam int WLEN_W    = 11;
    localparam int THR_W     = 20;
    localparam int START_W   = 21;

    // Tap select tree: first level picks a lane inside each group,
    // second level picks the group.
    localparam int GROUP_SIZE = 32;
    localparam int LANE_W     = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS = WINDOW_MAX / GROUP_SIZE;
    localparam int GRP_IDX_W  = WIN_IDX_W - LANE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 1'd1;

    // Running minimum and maximum held by one cell
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
    } t_minmax;

    // Input request
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } t_in_item;

    // Output request
    typedef struct packed {
        logic [START_W-1:0] start_position;
        logic               none_found;
    } t_out_item;

endpackage

// ===== hw/rtl/swrd_cell.sv =====
// ============================================================================
// swrd_cell
// One cell of the min/max row: merges the new sample into its neighbor's
// running extremes, so cell k covers the k+1 most recent samples.
// ============================================================================
module swrd_cell (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [swrd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  swrd_pkg::t_minmax                i_prev,
    output swrd_pkg::t_minmax                o_cell
);
    import swrd_pkg::*;

    t_minmax r_cell;
    t_minmax n_cell;

    // Merge the new sample with the neighbor's previous extremes
    always_comb begin
        n_cell.lo = (i_sample < i_prev.lo) ? i_sample : i_prev.lo;
        n_cell.hi = (i_sample > i_prev.hi) ? i_sample : i_prev.hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== hw/rtl/swrd_chain.sv =====
// ============================================================================
// swrd_chain
// Row of WINDOW_MAX cells. On each accepted sample every cell takes its
// left neighbor's extremes merged with the sample.
// ============================================================================
module swrd_chain (
    input  logic                                              i_clk,
    input  logic                                              i_en,
    input  logic [swrd_pkg::SAMPLE_BITS-1:0]                  i_sample,
    output swrd_pkg::t_minmax [swrd_pkg::WINDOW_MAX-1:0]      o_cells
);
    import swrd_pkg::*;

    t_minmax w_head;

    // First cell sees the sample alone
    assign w_head.lo = i_sample;
    assign w_head.hi = i_sample;

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        if (k == 0) begin : g_first
            swrd_cell u_cell (
                .i_clk    (i_clk),
                .i_en     (i_en),
                .i_sample (i_sample),
                .i_prev   (w_head),
                .o_cell   (o_cells[k])
            );
        end else begin : g_rest
            swrd_cell u_cell (
                .i_clk    (i_clk),
                .i_en     (i_en),
                .i_sample (i_sample),
                .i_prev   (o_cells[k-1]),
                .o_cell   (o_cells[k])
            );
        end
    end

endmodule

// ===== hw/rtl/swrd_tap_select.sv =====
// ============================================================================
// swrd_tap_select
// Two-level registered select of the cell at the window tap: a lane is
// picked inside every group, then one group.
// ============================================================================
module swrd_tap_select (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [swrd_pkg::WIN_IDX_W-1:0]                i_tap,
    input  swrd_pkg::t_minmax [swrd_pkg::WINDOW_MAX-1:0]  i_cells,
    output swrd_pkg::t_minmax                             o_sel
);
    import swrd_pkg::*;

    t_minmax w_grp [NUM_GROUPS];
    t_minmax r_grp [NUM_GROUPS];
    t_minmax r_sel;

    logic [LANE_W-1:0]    w_lane;
    logic [GRP_IDX_W-1:0] w_group;

    assign w_lane  = i_tap[LANE_W-1:0];
    assign w_group = i_tap[WIN_IDX_W-1:LANE_W];

    // Level one: lane select inside each group
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        assign w_grp[g] = i_cells[{GRP_IDX_W'(g), w_lane}];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp <= w_grp;
        end
    end

    // Level two: group select
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= r_grp[w_group];
        end
    end

    assign o_sel = r_sel;

endmodule

// ===== hw/rtl/sliding_window_range_detector.sv =====
// ============================================================================
// sliding_window_range_detector
// Sliding-window max/min range check over a sample stream.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one sample
//   per request, with a last flag on the final sample of a sequence.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries the
//   1-based start of each full window whose max - min is within threshold,
//   or one none-found request when a sequence ends without a match.
//   Configuration (i_cfg_we / i_cfg_index / i_cfg_data) sets the window
//   length and threshold; write it only with no request in flight.
// Timing:
//   A request passes stages A, B and C before its result is registered at
//   the output. One request per cycle is sustained while the output is not
//   stalled: the row of WINDOW_MAX cells updates all running extremes at
//   once and the tap select is a two-stage registered tree.
// Reset:
//   Synchronous, active low. Window length returns to 1024, threshold to 0,
//   and the position count and match flag clear. No clearing pass.
// Backpressure:
//   The whole pipeline advances only while the output register is empty or
//   being taken, so an output stall raises o_in_stall in the same cycle.
// ============================================================================
module sliding_window_range_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  swrd_pkg::t_in_item                 i_in_data,
    // Output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output swrd_pkg::t_out_item                o_out_data,
    // Configuration
    input  logic                               i_cfg_we,
    input  logic [swrd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swrd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import swrd_pkg::*;

    // Configuration registers (window length kept as tap index = length - 1)
    logic [WIN_IDX_W-1:0] r_tap;
    logic [THR_W-1:0]     r_thr;
    logic [WLEN_W-1:0]    w_wlen;

    // Pipeline control
    logic w_en;
    logic w_accept;

    // Sequence position, counted at the input
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] w_pos_inc;

    // Stage A: request just merged into the cells
    logic             r_a_valid;
    logic [POS_W-1:0] r_a_pos;
    logic             r_a_last;

    // Stage B: level-one select done
    logic               r_b_valid;
    logic               r_b_full;
    logic [START_W-1:0] r_b_start;
    logic               r_b_last;

    // Stage C: tap extremes ready
    logic               r_c_valid;
    logic               r_c_full;
    logic [START_W-1:0] r_c_start;
    logic               r_c_last;

    // Match tracking and output register
    logic       r_any_match;
    logic       n_any_match;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_item  r_out_data;
    t_out_item  n_out_data;

    t_minmax [WINDOW_MAX-1:0] w_cells;
    t_minmax                  w_sel;
    logic [SAMPLE_BITS-1:0]   w_span;
    logic                     w_hit;

    // Handshake
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;

    // Configuration writes
    assign w_wlen = i_cfg_data[WLEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= WIN_IDX_W'(WINDOW_MAX - 1);
            r_thr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW_LENGTH: begin
                    if (w_wlen == '0) begin
                        r_tap <= '0;
                    end else if (w_wlen > WLEN_W'(WINDOW_MAX)) begin
                        r_tap <= WIN_IDX_W'(WINDOW_MAX - 1);
                    end else begin
                        r_tap <= WIN_IDX_W'(w_wlen - WLEN_W'(1));
                    end
                end
                REG_THRESHOLD: begin
                    r_thr <= i_cfg_data[THR_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Saturating position count, restarts after the last sample
    assign w_pos_inc = (r_pos < POS_W'(POSITION_MAX)) ? r_pos + POS_W'(1) : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_accept) begin
            r_pos <= i_in_data.last ? '0 : w_pos_inc;
        end
    end

    // Cell row and tap select
    swrd_chain u_chain (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_sample (i_in_data.sample),
        .o_cells  (w_cells)
    );

    swrd_tap_select u_select (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_tap   (r_tap),
        .i_cells (w_cells),
        .o_sel   (w_sel)
    );

    // Request tags travel alongside the select stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_pos   <= w_pos_inc;
            r_a_last  <= i_in_data.last;
            // window full once position reaches length; start = pos - length + 1
            r_b_full  <= r_a_pos > POS_W'(r_tap);
            r_b_start <= START_W'(r_a_pos - POS_W'(r_tap));
            r_b_last  <= r_a_last;
            r_c_full  <= r_b_full;
            r_c_start <= r_b_start;
            r_c_last  <= r_b_last;
        end
    end

    // Range check and result
    assign w_span = w_sel.hi - w_sel.lo;
    assign w_hit  = r_c_full && (THR_W'(w_span) <= r_thr);

    always_comb begin
        n_any_match = r_any_match;
        n_out_valid = 1'b0;
        n_out_data  = r_out_data;
        if (r_c_valid) begin
            if (w_hit) begin
                n_out_valid               = 1'b1;
                n_out_data.start_position = r_c_start;
                n_out_data.none_found     = 1'b0;
                n_any_match               = 1'b1;
            end else if (r_c_last && !r_any_match) begin
                n_out_valid               = 1'b1;
                n_out_data.start_position = '0;
                n_out_data.none_found     = 1'b1;
            end
            if (r_c_last) begin
                n_any_match = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_match <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_any_match <= n_any_match;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
